// ===== rtl/pil_pkg.sv =====
package pil_pkg;

   // list size and derived widths
   localparam int CAPACITY = 128;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // word field widths
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

// ===== rtl/packed_id_list_table.sv =====
// Packed identifier list held in one synchronous RAM (one write and one read port,
// registered read). A request is taken when start is high and busy is low; its
// response appears on the rsp_ ports for exactly one cycle with rsp_strobe high and
// must be captured then, since the block cannot be held off. The search walks the
// RAM one entry per cycle until a match or the end of the list. A remove that hits
// at position p then moves the later entries down one per cycle. A new request may
// be started in the cycle the previous response is shown. Any kind code other than
// remove or append behaves as a lookup. No clearing pass is needed after reset.
module packed_id_list_table
   import pil_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_strobe,
   output logic                rsp_hit,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

   typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_SHIFT} state_type;

   // entry storage
   logic [KEY_W-1:0] mem [CAPACITY];

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              chk_ff, chk_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [KEY_W-1:0]  rd_data_ff;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;

   // ram: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_addr = ptr_ff[IDX_W-1:0];

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff - IDX_W'(1);
      wr_data       = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               key_in   = req_key;
               ptr_in   = '0;
               chk_in   = 1'b0;
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // compare the word read last cycle, else issue the next read
            if (chk_ff && (rd_data_ff == key_ff)) begin
               chk_in = 1'b0;
               if (kind_ff == KIND_REMOVE) begin
                  ptr_in   = CNT_W'(chk_idx_ff) + CNT_W'(1);
                  state_in = ST_SHIFT;
               end else if (kind_ff == KIND_APPEND) begin
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_hit_in    = 1'b1;
                  if (cnt_ff < CNT_W'(CAPACITY)) begin
                     wr_en         = 1'b1;
                     wr_addr       = cnt_ff[IDX_W-1:0];
                     wr_data       = key_ff;
                     cnt_in        = cnt_ff + CNT_W'(1);
                     rsp_status_in = STATUS_DONE;
                     rsp_count_in  = COUNT_W'(cnt_ff + CNT_W'(1));
                  end else begin
                     rsp_status_in = STATUS_FULL;
                     rsp_count_in  = COUNT_W'(cnt_ff);
                  end
               end else begin
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_hit_in    = 1'b1;
                  rsp_status_in = STATUS_DONE;
                  rsp_count_in  = COUNT_W'(cnt_ff);
               end
            end else if (ptr_ff == cnt_ff) begin
               // end of list without a match
               chk_in        = 1'b0;
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_status_in = STATUS_DONE;
               rsp_count_in  = COUNT_W'(cnt_ff);
               if (kind_ff == KIND_REMOVE) begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end else if (kind_ff == KIND_APPEND) begin
                  if (cnt_ff < CNT_W'(CAPACITY)) begin
                     wr_en        = 1'b1;
                     wr_addr      = cnt_ff[IDX_W-1:0];
                     wr_data      = key_ff;
                     cnt_in       = cnt_ff + CNT_W'(1);
                     rsp_count_in = COUNT_W'(cnt_ff + CNT_W'(1));
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
            end else begin
               chk_in     = 1'b1;
               chk_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in     = ptr_ff + CNT_W'(1);
            end
         end

         ST_SHIFT: begin
            // write back the word read last cycle one place lower
            if (chk_ff) begin
               wr_en = 1'b1;
            end
            if (ptr_ff == cnt_ff) begin
               chk_in        = 1'b0;
               cnt_in        = cnt_ff - CNT_W'(1);
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_hit_in    = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_count_in  = COUNT_W'(cnt_ff - CNT_W'(1));
            end else begin
               chk_in     = 1'b1;
               chk_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in     = ptr_ff + CNT_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         chk_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_ff        <= chk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pil_pkg::*;

   // kind code the block treats as a lookup
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } list_outcome_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      bit                typed;
      list_outcome_type  want;
   } directed_word_type;

   typedef struct {
      int unsigned words;
      int unsigned append_pct;
      int unsigned remove_pct;
      int unsigned held_key_pct;
      bit          idling;
   } traffic_phase_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [KIND_W-1:0]  req_kind = '0;
   logic [KEY_W-1:0]   req_key = '0;
   logic               busy;
   logic               rsp_strobe;
   logic               rsp_hit;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;

   // mirror of the packed list and the responses still owed by the block
   logic [KEY_W-1:0] id_list[$];
   list_outcome_type due_outcomes[$];
   int unsigned      error_count = 0;

   // duplicates, wrap-round keys and all four kinds, from an empty list
   directed_word_type directed_words[20] = '{
      '{KIND_LOOKUP, 16'h0000, 1'b1, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'hFFFF, 1'b1, '{1'b0, STATUS_NOT_FOUND, 8'd0}},
      '{KIND_SPARE,  16'h1234, 1'b1, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_APPEND, 16'h0000, 1'b1, '{1'b0, STATUS_DONE,      8'd1}},
      '{KIND_APPEND, 16'hFFFF, 1'b1, '{1'b0, STATUS_DONE,      8'd2}},
      '{KIND_APPEND, 16'h0000, 1'b1, '{1'b1, STATUS_DONE,      8'd3}},
      '{KIND_LOOKUP, 16'hFFFF, 1'b1, '{1'b1, STATUS_DONE,      8'd3}},
      '{KIND_LOOKUP, 16'h8000, 1'b1, '{1'b0, STATUS_DONE,      8'd3}},
      '{KIND_SPARE,  16'hFFFF, 1'b1, '{1'b1, STATUS_DONE,      8'd3}},
      '{KIND_APPEND, 16'h5A5A, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_APPEND, 16'hA5A5, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'h0000, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_LOOKUP, 16'h0000, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'h5A5A, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'h0001, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'hA5A5, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'hFFFF, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'h0000, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_REMOVE, 16'h0000, 1'b0, '{1'b0, STATUS_DONE,      8'd0}},
      '{KIND_APPEND, 16'h7FFF, 1'b0, '{1'b0, STATUS_DONE,      8'd0}}
   };

   // fill to full, drain to empty, churn without gaps, then once more
   traffic_phase_type traffic_phases[5] = '{
      '{200, 85,  5, 40, 1'b1},
      '{200,  3, 90, 80, 1'b1},
      '{150, 35, 35, 50, 1'b0},
      '{150, 80, 10, 40, 1'b1},
      '{150,  5, 85, 80, 1'b1}
   };

   packed_id_list_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_kind   (req_kind),
      .req_key    (req_key),
      .rsp_strobe (rsp_strobe),
      .rsp_hit    (rsp_hit),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // one line per mismatch, tallied for the final verdict
   task automatic report_mismatch(input string note);
      $display("mismatch at %0t: %s", $realtime, note);
      error_count++;
   endtask

   // apply one word to the mirrored list and work out the response it earns
   function automatic list_outcome_type update_id_list(input logic [KIND_W-1:0] kind,
                                                       input logic [KEY_W-1:0] key);
      list_outcome_type outcome;
      int               pos;
      pos = -1;
      foreach (id_list[i]) begin
         if (pos < 0 && id_list[i] == key) pos = i;
      end
      outcome.hit    = (pos >= 0);
      outcome.status = STATUS_DONE;
      unique case (kind)
         KIND_REMOVE: begin
            if (pos >= 0) id_list.delete(pos);
            else outcome.status = STATUS_NOT_FOUND;
         end
         KIND_APPEND: begin
            if (id_list.size() < CAPACITY) id_list.push_back(key);
            else outcome.status = STATUS_FULL;
         end
         default: ;
      endcase
      outcome.count = COUNT_W'(id_list.size());
      return outcome;
   endfunction

   // held key, small pool for duplicates, extremes, or anything at all
   function automatic logic [KEY_W-1:0] pick_key(input int unsigned held_pct);
      int unsigned draw;
      draw = $urandom_range(99);
      if (draw < held_pct && id_list.size() != 0)
         return id_list[$urandom_range(id_list.size() - 1)];
      else if (draw < held_pct + 15)
         return KEY_W'($urandom_range(15));
      else if (draw < held_pct + 22)
         return $urandom_range(1) ? '1 : '0;
      else
         return KEY_W'($urandom_range(16'hFFFF));
   endfunction

   // offer one word, with an optional gap first, and return once it is taken
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                            input bit idling);
      if (idling && $urandom_range(99) < 29) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 60);
      end
      start    <= 1'b1;
      req_kind <= kind;
      req_key  <= key;
      do @(posedge clock); while (busy);
   endtask

   // response checker
   always @(posedge clock) begin
      list_outcome_type want;
      if (!reset && rsp_strobe) begin
         if (due_outcomes.size() == 0) begin
            report_mismatch("response with no word awaiting one");
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit expected %0b got %0b", want.hit, rsp_hit));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status expected %0d got %0d",
                                         want.status, rsp_status));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("count expected %0d got %0d",
                                         want.count, rsp_count));
         end
      end
   end

   // stimulus
   initial begin
      list_outcome_type  predicted;
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      int unsigned       draw;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i]) begin
         send_word(directed_words[i].kind, directed_words[i].key, 1'b1);
         predicted = update_id_list(directed_words[i].kind, directed_words[i].key);
         due_outcomes.push_back(directed_words[i].typed ? directed_words[i].want : predicted);
      end

      foreach (traffic_phases[p]) begin
         for (int unsigned n = 0; n < traffic_phases[p].words; n++) begin
            draw = $urandom_range(99);
            if (draw < traffic_phases[p].append_pct)
               kind = KIND_APPEND;
            else if (draw < traffic_phases[p].append_pct + traffic_phases[p].remove_pct)
               kind = KIND_REMOVE;
            else if (draw < traffic_phases[p].append_pct + traffic_phases[p].remove_pct + 3)
               kind = KIND_SPARE;
            else
               kind = KIND_LOOKUP;
            key = pick_key(kind == KIND_APPEND ? 10 : traffic_phases[p].held_key_pct);
            send_word(kind, key, traffic_phases[p].idling);
            due_outcomes.push_back(update_id_list(kind, key));
         end
      end
      start <= 1'b0;

      // let the last responses arrive, then allow a full search and shift
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (2 * CAPACITY + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
